@@ rtl/lirs_pkg.sv @@
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lirs_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int FRAC_ONE    = 65536;
  localparam int FRAC_HALF   = 32768;
  localparam int STEP_BITS   = 21;
  localparam int RATIO_BITS  = 20;
  localparam int SENT_BITS   = 28;
  localparam int MAX_RESULTS = 18;
  localparam int RES_CNT_BITS = 5;
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 21'd65536;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 20'd65536;

  // register index, byte address = 4 * index
  typedef enum logic [1:0] {
    REG_STEP  = 2'd0,
    REG_RATIO = 2'd1,
    REG_MONO  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  step;
    logic [RATIO_BITS-1:0] ratio;
    logic                  mono;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_ACC,
    ST_SETUP,
    ST_NEXT,
    ST_MUL_L,
    ST_MUL_R,
    ST_EMIT,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic tgt_issue;
    logic tgt_acc;
    logic setup;
    logic pos_update;
    logic finish;
    logic mul_left;
    logic mul_right;
    logic emit;
    logic taken;
  } ctrl_t;

endpackage

@@ rtl/lirs_cfg.sv @@
// Configuration register file with an APB-style slave port.
// Depends on lirs_pkg (cfg_t, reg_idx_t, reset values).
`timescale 1ns / 1ps

module lirs_cfg
  import lirs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step  <= STEP_RESET;
      cfg.ratio <= RATIO_RESET;
      cfg.mono  <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_STEP:  cfg.step  <= pwdata[STEP_BITS-1:0];
        REG_RATIO: cfg.ratio <= pwdata[RATIO_BITS-1:0];
        REG_MONO:  cfg.mono  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STEP:  prdata = DATA_BITS'(cfg.step);
      REG_RATIO: prdata = DATA_BITS'(cfg.ratio);
      REG_MONO:  prdata = DATA_BITS'(cfg.mono);
      default:   prdata = '0;
    endcase
  end

endmodule

@@ rtl/lirs_mul.sv @@
// Shared signed-by-unsigned multiplier with registered product.
// Depends on lirs_pkg (FRAC_BITS). Used for both mixing and output count.
`timescale 1ns / 1ps

module lirs_mul
  import lirs_pkg::*;
#(
  parameter int AW = 25
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [AW-1:0]          a,
  input  logic        [FRAC_BITS-1:0]   b,
  output logic signed [AW+FRAC_BITS-1:0] p
);

  logic signed [AW+FRAC_BITS:0] full;

  assign full = a * $signed({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[AW+FRAC_BITS-1:0];
    end
  end

endmodule

@@ rtl/linear_interp_resampler.sv @@
// Stereo linear interpolation resampler: one frame in, zero to 18 results out.
// After the frame transfer, each interpolated result passes the NEXT, MUL_L, MUL_R and EMIT
// states before it is shown; held repeats of a last frame pass only NEXT and EMIT.
// A last frame first computes the output count, one TGT_MUL/TGT_ACC pair per 16-bit chunk of frames+1.
// A new frame is taken only in the idle state, once the previous frame and its results are done;
// the single multiplier sets the pace, and output stalls hold it.
// Reset (rst, synchronous) clears the sequencer and stream state and reloads register defaults.
`timescale 1ns / 1ps

module linear_interp_resampler
  import lirs_pkg::*;
#(
  parameter int SAMPLE_BITS      = 24,
  parameter int FRAME_COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_BITS-1:0]          paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          frame_valid,
  output logic                          frame_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  input  logic                          last_frame,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                          run_end,
  output logic                          stream_end
);

  localparam int SB       = SAMPLE_BITS;
  localparam int FCB      = FRAME_COUNT_BITS;
  localparam int POS_BITS = FCB + FRAC_BITS;
  localparam int NCH      = (FCB + FRAC_BITS) / FRAC_BITS;
  localparam int KW       = NCH * FRAC_BITS;
  localparam int ACC_W    = KW + RATIO_BITS;
  localparam int TW       = ACC_W - FRAC_BITS + 1;
  localparam int CMP_W    = (TW > SENT_BITS) ? TW : SENT_BITS;
  localparam int CW       = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int AW       = (SB + 1 > RATIO_BITS + 1) ? SB + 1 : RATIO_BITS + 1;
  localparam int PW       = AW + FRAC_BITS;
  localparam int MW       = SB + FRAC_BITS + 2;

  cfg_t   cfg;
  state_t state, state_next;
  ctrl_t  ctrl;

  // stream state
  logic signed [SB-1:0]       prev_l, prev_r;
  logic                       have_prev;
  logic [POS_BITS-1:0]        next_pos;
  logic [FCB-1:0]             frames_seen;
  logic [SENT_BITS-1:0]       sent;

  // per-frame working registers
  logic signed [SB-1:0]       cur_l, cur_r;
  logic                       last_flag;
  logic [KW-1:0]              kreg;
  logic [CW-1:0]              cnt;
  logic [ACC_W-1:0]           acc;
  logic [TW-1:0]              target;
  logic [POS_BITS-1:0]        rel;
  logic [RES_CNT_BITS-1:0]    n_cnt;
  logic                       interp_phase;
  logic signed [SB-1:0]       mix_l;

  // combinational datapath
  logic [POS_BITS-1:0]        base, rel_init, rel_adv;
  logic [FCB:0]               k1;
  logic                       rel_lt_one, n_room, sent_lt_tgt, interp_ok, hold_ok;
  logic [RES_CNT_BITS-1:0]    n_adv;
  logic [SENT_BITS-1:0]       sent_adv;
  logic                       adv_lt_one, adv_room, adv_lt_tgt, more;
  logic signed [SB-1:0]       prev_r_eff;
  logic signed [SB:0]         diff_l, diff_r;
  logic signed [AW-1:0]       mul_a;
  logic [FRAC_BITS-1:0]       mul_b;
  logic                       mul_en;
  logic signed [PW-1:0]       prod;
  logic [ACC_W-1:0]           acc_next;
  logic [ACC_W:0]             tgt_sum;

  function automatic logic signed [SB-1:0] mix_round(input logic signed [SB-1:0] a,
                                                     input logic signed [PW-1:0] p);
    logic signed [MW-1:0] s;
    s = (MW'(a) <<< FRAC_BITS) + MW'(p) + MW'(FRAC_HALF);
    return s[SB+FRAC_BITS-1:FRAC_BITS];
  endfunction

  lirs_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lirs_mul #(.AW(AW)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // ---------------- loop conditions ----------------
  assign base        = {frames_seen - FCB'(1), {FRAC_BITS{1'b0}}};
  assign rel_init    = next_pos - base;
  assign k1          = {1'b0, frames_seen} + (FCB + 1)'(1);
  assign rel_lt_one  = ~|rel[POS_BITS-1:FRAC_BITS];
  assign n_room      = n_cnt < RES_CNT_BITS'(MAX_RESULTS);
  assign sent_lt_tgt = CMP_W'(sent) < CMP_W'(target);
  assign interp_ok   = rel_lt_one && n_room && (!last_flag || sent_lt_tgt);
  assign hold_ok     = last_flag && sent_lt_tgt && n_room;

  // lookahead: does another result follow the one being loaded
  assign rel_adv    = rel + POS_BITS'(cfg.step);
  assign n_adv      = n_cnt + RES_CNT_BITS'(1);
  assign sent_adv   = (&sent) ? sent : sent + SENT_BITS'(1);
  assign adv_lt_one = ~|rel_adv[POS_BITS-1:FRAC_BITS];
  assign adv_room   = n_adv < RES_CNT_BITS'(MAX_RESULTS);
  assign adv_lt_tgt = CMP_W'(sent_adv) < CMP_W'(target);
  assign more       = (interp_phase && adv_lt_one && adv_room && (!last_flag || adv_lt_tgt))
                   || (last_flag && adv_lt_tgt && adv_room);

  // ---------------- shared multiplier operands ----------------
  assign prev_r_eff = cfg.mono ? prev_l : prev_r;
  assign diff_l     = {cur_l[SB-1], cur_l} - {prev_l[SB-1], prev_l};
  assign diff_r     = {cur_r[SB-1], cur_r} - {prev_r_eff[SB-1], prev_r_eff};

  always_comb begin
    if (ctrl.tgt_issue) begin
      mul_a = AW'($signed({1'b0, cfg.ratio}));
      mul_b = kreg[KW-1 -: FRAC_BITS];
    end else if (ctrl.mul_right) begin
      mul_a = AW'(diff_r);
      mul_b = rel[FRAC_BITS-1:0];
    end else begin
      mul_a = AW'(diff_l);
      mul_b = rel[FRAC_BITS-1:0];
    end
  end

  assign mul_en = ctrl.tgt_issue | ctrl.mul_left | ctrl.mul_right;

  // output count: chunks of (frames+1) enter most significant first
  assign acc_next = {acc[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}
                  + ACC_W'(prod[RATIO_BITS+FRAC_BITS-1:0]);
  assign tgt_sum  = {1'b0, acc_next} + (ACC_W + 1)'(FRAC_HALF);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (frame_valid) state_next = last_frame ? ST_TGT_MUL : ST_SETUP;
      ST_TGT_MUL: state_next = ST_TGT_ACC;
      ST_TGT_ACC: state_next = (cnt == '0) ? ST_SETUP : ST_TGT_MUL;
      ST_SETUP:   state_next = ST_NEXT;
      ST_NEXT: begin
        if (interp_phase) begin
          state_next = interp_ok ? ST_MUL_L : ST_NEXT;
        end else begin
          state_next = hold_ok ? ST_EMIT : ST_IDLE;
        end
      end
      ST_MUL_L:   state_next = ST_MUL_R;
      ST_MUL_R:   state_next = ST_EMIT;
      ST_EMIT:    state_next = ST_WAIT;
      ST_WAIT:    if (!result_stall) state_next = ST_NEXT;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:    ctrl.accept    = frame_valid;
      ST_TGT_MUL: ctrl.tgt_issue = 1'b1;
      ST_TGT_ACC: ctrl.tgt_acc   = 1'b1;
      ST_SETUP:   ctrl.setup     = 1'b1;
      ST_NEXT: begin
        ctrl.pos_update = interp_phase && !interp_ok;
        ctrl.finish     = !interp_phase && !hold_ok;
      end
      ST_MUL_L:   ctrl.mul_left  = 1'b1;
      ST_MUL_R:   ctrl.mul_right = 1'b1;
      ST_EMIT:    ctrl.emit      = 1'b1;
      ST_WAIT:    ctrl.taken     = !result_stall;
      default: begin
      end
    endcase
  end

  assign frame_stall = (state != ST_IDLE);

  // ---------------- control and stream state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      have_prev    <= 1'b0;
      prev_l       <= '0;
      prev_r       <= '0;
      next_pos     <= '0;
      frames_seen  <= '0;
      sent         <= '0;
      n_cnt        <= '0;
      interp_phase <= 1'b0;
      cnt          <= '0;
    end else begin
      if (ctrl.accept) begin
        n_cnt <= '0;
        cnt   <= CW'(NCH - 1);
      end
      if (ctrl.tgt_acc) begin
        cnt <= cnt - CW'(1);
      end
      if (ctrl.setup) begin
        interp_phase <= have_prev;
      end
      if (ctrl.pos_update) begin
        next_pos     <= base + (rel_lt_one ? POS_BITS'(FRAC_ONE) : rel);
        interp_phase <= 1'b0;
      end
      if (ctrl.emit) begin
        result_valid <= 1'b1;
        n_cnt        <= n_adv;
        sent         <= sent_adv;
      end
      if (ctrl.taken) begin
        result_valid <= 1'b0;
      end
      if (ctrl.finish) begin
        if (last_flag) begin
          have_prev   <= 1'b0;
          prev_l      <= '0;
          prev_r      <= '0;
          next_pos    <= '0;
          frames_seen <= '0;
          sent        <= '0;
        end else begin
          have_prev   <= 1'b1;
          prev_l      <= cur_l;
          prev_r      <= cur_r;
          frames_seen <= frames_seen + FCB'(1);
        end
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cur_l     <= left_sample;
      cur_r     <= cfg.mono ? left_sample : right_sample;
      last_flag <= last_frame;
      kreg      <= KW'(k1);
      acc       <= '0;
    end
    if (ctrl.tgt_issue) begin
      kreg <= kreg << FRAC_BITS;
    end
    if (ctrl.tgt_acc) begin
      acc    <= acc_next;
      target <= tgt_sum[ACC_W:FRAC_BITS];
    end
    if (ctrl.setup) begin
      // a position behind the current interval restarts at its start
      rel <= rel_init[POS_BITS-1] ? '0 : rel_init;
    end
    if (ctrl.mul_right) begin
      mix_l <= mix_round(prev_l, prod);
    end
    if (ctrl.emit) begin
      out_left   <= interp_phase ? mix_l : cur_l;
      out_right  <= interp_phase ? mix_round(prev_r_eff, prod) : cur_r;
      run_end    <= !more;
      stream_end <= last_flag && !more;
      if (interp_phase) begin
        rel <= rel_adv;
      end
    end
  end

  // ---------------- assertions ----------------
  a_valid_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> state == ST_WAIT)
    else $error("result shown outside the wait state");

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    n_cnt <= RES_CNT_BITS'(MAX_RESULTS))
    else $error("result count passed the per-frame cap");

  a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && stream_end) |-> run_end)
    else $error("stream end without run end");

  a_run_end_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && run_end) |=> !result_valid)
    else $error("result follows the one marked run end");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && !frame_stall) |=> frame_stall)
    else $error("second frame taken while one is in work");

endmodule
